FILE: src/aapr_pkg.sv
// Shared types, constants and arithmetic helpers for the axis-angle point rotator.
`default_nettype none

package aapr_pkg;

    typedef logic signed [31:0] word_t;

    // Point and clamped axis, carried alongside the angle path
    typedef struct packed {
        word_t px;
        word_t py;
        word_t pz;
        word_t ux;
        word_t uy;
        word_t uz;
    } side_t;

    localparam int CORDIC_STAGES_DEF = 24;
    localparam int FRONT_LAT         = 5;

    // Angles in Q16.16 degrees
    localparam logic [24:0] DEG90  = 25'd5898240;
    localparam logic [24:0] DEG270 = 25'd17694720;
    localparam logic [24:0] DEG360 = 25'd23592960;
    localparam logic [24:0] DEG180 = 25'd11796480;

    // r = (mag * PI_Q29 + 2949120) / (45 * 2^17), split as PI_Q29 = 45*QP + RP
    localparam logic [30:0] PI_Q29  = 31'd1686629713;
    localparam logic [25:0] QP      = 26'(PI_Q29 / 31'd45);
    localparam logic [3:0]  RP      = 4'(PI_Q29 % 31'd45);
    localparam logic [21:0] HALF_D  = 22'd2949120;
    localparam logic [27:0] RECIP45 = 28'((64'd8589934592 + 64'd44) / 64'd45);

    localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
    localparam logic signed [33:0] ONE_Q30  = 34'sd1073741824;

    function automatic logic [29:0] atan_q30(input logic [4:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:  v = 30'h3243F6A8;
            5'd1:  v = 30'h1DAC6705;
            5'd2:  v = 30'h0FADBAFC;
            5'd3:  v = 30'h07F56EA6;
            5'd4:  v = 30'h03FEAB76;
            5'd5:  v = 30'h01FFD55B;
            5'd6:  v = 30'h00FFFAAA;
            5'd7:  v = 30'h007FFF55;
            5'd8:  v = 30'h003FFFEA;
            5'd9:  v = 30'h001FFFFD;
            5'd10: v = 30'h000FFFFF;
            5'd11: v = 30'h0007FFFF;
            5'd12: v = 30'h0003FFFF;
            5'd13: v = 30'h0001FFFF;
            5'd14: v = 30'h0000FFFF;
            5'd15: v = 30'h00007FFF;
            5'd16: v = 30'h00003FFF;
            5'd17: v = 30'h00001FFF;
            5'd18: v = 30'h00000FFF;
            5'd19: v = 30'h000007FF;
            5'd20: v = 30'h000003FF;
            5'd21: v = 30'h000001FF;
            5'd22: v = 30'h000000FF;
            5'd23: v = 30'h0000007F;
            5'd24: v = 30'h0000003F;
            5'd25: v = 30'h0000001F;
            5'd26: v = 30'h0000000F;
            5'd27: v = 30'h00000007;
            5'd28: v = 30'h00000003;
            5'd29: v = 30'h00000001;
            default: v = 30'h00000000;
        endcase
        return v;
    endfunction

    // Q30 product, rounded half up (floor of product + 2^29)
    function automatic logic signed [33:0] mul30(input logic signed [33:0] a,
                                                 input logic signed [31:0] b);
        logic signed [65:0] prod;
        logic signed [65:0] sh;
        prod = a * b;
        prod = prod + 66'sd536870912;
        sh   = prod >>> 30;
        return sh[33:0];
    endfunction

endpackage

`default_nettype wire

FILE: src/axis_angle_point_rotate.sv
// Top level of the axis-angle (Rodrigues) point rotator.
//
// Input channel: item_valid / item_stall carry one word per cycle unless
// stalled: a Q16.16 point, a Q1.30 unit axis (components clamped to +-1.0) and
// a Q10.16 angle in degrees. Output channel: rot_valid / rot_stall carry the
// rotated Q16.16 point and an overflow flag set when any coordinate saturated.
//
// Pipeline: 5 angle stages, one per CORDIC iteration, one cos fixup stage,
// 5 matrix and product stages incl. the output register. Throughput: one
// word per cycle while rot_stall does not hold the pipe; the pipeline is a
// straight chain of registers.
//
// All stages share one advance enable. While rot_valid is high and
// rot_stall is high the whole pipe holds, item_stall is raised, and the
// output word stays put. Bubbles travel as cleared valid bits.
//
// Reset (rst_n low, async) clears every valid bit; the data path is not
// reset. No warm-up is needed after reset.
`default_nettype none

module axis_angle_point_rotate
    import aapr_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
)
(
    input  wire                clk,
    input  wire                rst_n,
    input  wire                item_valid,
    output logic               item_stall,
    input  wire  signed [31:0] point_x,
    input  wire  signed [31:0] point_y,
    input  wire  signed [31:0] point_z,
    input  wire  signed [31:0] axis_x,
    input  wire  signed [31:0] axis_y,
    input  wire  signed [31:0] axis_z,
    input  wire  signed [25:0] angle_deg,
    output logic               rot_valid,
    input  wire                rot_stall,
    output logic signed [31:0] rot_x,
    output logic signed [31:0] rot_y,
    output logic signed [31:0] rot_z,
    output logic               overflow
);

    localparam int SIDE_DEPTH = FRONT_LAT + CORDIC_STAGES + 1;

    logic en;
    assign en         = !(rot_valid && rot_stall);
    assign item_stall = !en;

    // axis clamp to +-1.0
    function automatic word_t clamp_axis(input word_t u);
        word_t r;
        if (u > 32'sd1073741824)
            r = 32'sd1073741824;
        else if (u < -32'sd1073741824)
            r = -32'sd1073741824;
        else
            r = u;
        return r;
    endfunction

    side_t side_in;
    assign side_in.px = point_x;
    assign side_in.py = point_y;
    assign side_in.pz = point_z;
    assign side_in.ux = clamp_axis(axis_x);
    assign side_in.uy = clamp_axis(axis_y);
    assign side_in.uz = clamp_axis(axis_z);

    // point/axis delay line matched to the angle path
    side_t side_reg [SIDE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            for (int i = 1; i < SIDE_DEPTH; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    logic               fr_valid;
    logic signed [33:0] fr_z;
    logic               fr_neg;

    aapr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (item_valid),
        .angle_deg (angle_deg),
        .valid_out (fr_valid),
        .z_out     (fr_z),
        .neg_out   (fr_neg)
    );

    logic               cd_valid;
    logic signed [33:0] cd_cos;
    logic signed [33:0] cd_sin;
    logic signed [33:0] cd_omc;

    aapr_cordic #(
        .STAGES (CORDIC_STAGES)
    ) u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (fr_valid),
        .z_in      (fr_z),
        .neg_in    (fr_neg),
        .valid_out (cd_valid),
        .cos_out   (cd_cos),
        .sin_out   (cd_sin),
        .omc_out   (cd_omc)
    );

    aapr_rotate u_rotate (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (cd_valid),
        .cos_in    (cd_cos),
        .sin_in    (cd_sin),
        .omc_in    (cd_omc),
        .side_in   (side_reg[SIDE_DEPTH-1]),
        .valid_out (rot_valid),
        .rot_x     (rot_x),
        .rot_y     (rot_y),
        .rot_z     (rot_z),
        .overflow  (overflow)
    );

endmodule

`default_nettype wire

FILE: src/aapr_front.sv
// Angle front end: modulo 360, quadrant fold, degrees to Q2.30 radians.
`default_nettype none

module aapr_front
    import aapr_pkg::*;
(
    input  wire                clk,
    input  wire                rst_n,
    input  wire                en,
    input  wire                valid_in,
    input  wire  signed [25:0] angle_deg,
    output logic               valid_out,
    output logic signed [33:0] z_out,
    output logic               neg_out
);

    // stage 1: reduce into [0, 360)
    logic signed [26:0] v;
    logic signed [26:0] d27;
    logic signed [26:0] red;
    logic        [24:0] a_reg;
    logic               v1_reg;

    assign v   = 27'(angle_deg);
    assign d27 = $signed({2'b00, DEG360});

    always_comb
    begin
        if (v < -d27)
            red = v + d27 + d27;
        else if (v < 27'sd0)
            red = v + d27;
        else if (v >= d27)
            red = v - d27;
        else
            red = v;
    end

    // stage 2: fold into [-90, 90]
    logic signed [25:0] aw;
    logic signed [25:0] fold;
    logic               fold_neg;
    logic signed [25:0] fold_abs;
    logic        [22:0] mag_reg;
    logic               sgn2_reg;
    logic               neg2_reg;
    logic               v2_reg;

    assign aw = $signed({1'b0, a_reg});

    always_comb
    begin
        fold_neg = 1'b0;
        if (a_reg <= DEG90)
            fold = aw;
        else if (a_reg < DEG270)
        begin
            fold     = $signed({1'b0, DEG180}) - aw;
            fold_neg = 1'b1;
        end
        else
            fold = aw - $signed({1'b0, DEG360});
        fold_abs = (fold < 26'sd0) ? -fold : fold;
    end

    // stage 3/4/5: radians
    logic [48:0] a3_reg;
    logic [26:0] b3_reg;
    logic        sgn3_reg;
    logic        neg3_reg;
    logic        v3_reg;
    logic [54:0] bprod;
    logic [48:0] a4_reg;
    logic [20:0] bq4_reg;
    logic        sgn4_reg;
    logic        neg4_reg;
    logic        v4_reg;
    logic [48:0] rsum;
    logic signed [33:0] rmag;
    logic signed [33:0] z5_reg;
    logic        neg5_reg;
    logic        v5_reg;

    assign bprod = 55'(b3_reg) * 55'(RECIP45);
    assign rsum  = a4_reg + 49'(bq4_reg);
    assign rmag  = $signed({2'b00, rsum[48:17]});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg    <= red[24:0];
            mag_reg  <= fold_abs[22:0];
            sgn2_reg <= fold[25];
            neg2_reg <= fold_neg;
            a3_reg   <= 49'(mag_reg) * 49'(QP);
            b3_reg   <= 27'(mag_reg) * 27'(RP) + 27'(HALF_D);
            sgn3_reg <= sgn2_reg;
            neg3_reg <= neg2_reg;
            a4_reg   <= a3_reg;
            bq4_reg  <= bprod[53:33];
            sgn4_reg <= sgn3_reg;
            neg4_reg <= neg3_reg;
            z5_reg   <= sgn4_reg ? -rmag : rmag;
            neg5_reg <= neg4_reg;
        end
    end

    assign valid_out = v5_reg;
    assign z_out     = z5_reg;
    assign neg_out   = neg5_reg;

endmodule

`default_nettype wire

FILE: src/aapr_cordic.sv
// Unrolled rotation-mode CORDIC, one register stage per iteration, plus cos fixup.
`default_nettype none

module aapr_cordic
    import aapr_pkg::*;
#(
    parameter int STAGES = CORDIC_STAGES_DEF
)
(
    input  wire                clk,
    input  wire                rst_n,
    input  wire                en,
    input  wire                valid_in,
    input  wire  signed [33:0] z_in,
    input  wire                neg_in,
    output logic               valid_out,
    output logic signed [33:0] cos_out,
    output logic signed [33:0] sin_out,
    output logic signed [33:0] omc_out
);

    logic signed [33:0] x_reg [STAGES];
    logic signed [33:0] y_reg [STAGES];
    logic signed [33:0] z_reg [STAGES];
    logic               neg_reg [STAGES];
    logic               v_reg [STAGES];

    for (genvar i = 0; i < STAGES; i++)
    begin : g_stage
        logic signed [33:0] sx;
        logic signed [33:0] sy;
        logic signed [33:0] sz;
        logic               sn;
        logic               sv;
        logic signed [33:0] at;

        if (i == 0)
        begin : g_first
            assign sx = GAIN_Q30;
            assign sy = 34'sd0;
            assign sz = z_in;
            assign sn = neg_in;
            assign sv = valid_in;
        end
        else
        begin : g_next
            assign sx = x_reg[i-1];
            assign sy = y_reg[i-1];
            assign sz = z_reg[i-1];
            assign sn = neg_reg[i-1];
            assign sv = v_reg[i-1];
        end

        assign at = $signed({4'b0000, atan_q30(5'(i))});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[i] <= 1'b0;
            else if (en)
                v_reg[i] <= sv;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                neg_reg[i] <= sn;
                if (sz >= 34'sd0)
                begin
                    x_reg[i] <= sx - (sy >>> i);
                    y_reg[i] <= sy + (sx >>> i);
                    z_reg[i] <= sz - at;
                end
                else
                begin
                    x_reg[i] <= sx + (sy >>> i);
                    y_reg[i] <= sy - (sx >>> i);
                    z_reg[i] <= sz + at;
                end
            end
        end
    end

    // cos sign restore and t = 1 - cos
    logic signed [33:0] c_reg;
    logic signed [33:0] s_reg;
    logic signed [33:0] t_reg;
    logic               vf_reg;
    logic signed [33:0] xl;

    assign xl = x_reg[STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vf_reg <= 1'b0;
        else if (en)
            vf_reg <= v_reg[STAGES-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg <= neg_reg[STAGES-1] ? -xl : xl;
            t_reg <= neg_reg[STAGES-1] ? ONE_Q30 + xl : ONE_Q30 - xl;
            s_reg <= y_reg[STAGES-1];
        end
    end

    assign valid_out = vf_reg;
    assign cos_out   = c_reg;
    assign sin_out   = s_reg;
    assign omc_out   = t_reg;

endmodule

`default_nettype wire

FILE: src/aapr_rotate.sv
// Rodrigues matrix build, matrix-vector product, rounding and saturation.
`default_nettype none

module aapr_rotate
    import aapr_pkg::*;
(
    input  wire                clk,
    input  wire                rst_n,
    input  wire                en,
    input  wire                valid_in,
    input  wire  signed [33:0] cos_in,
    input  wire  signed [33:0] sin_in,
    input  wire  signed [33:0] omc_in,
    input  side_t              side_in,
    output logic               valid_out,
    output logic signed [31:0] rot_x,
    output logic signed [31:0] rot_y,
    output logic signed [31:0] rot_z,
    output logic               overflow
);

    logic [4:0] v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[3:0], valid_in};
    end

    // R1: t*u and s*u
    logic signed [33:0] tx1_reg, ty1_reg, tz1_reg, sx1_reg, sy1_reg, sz1_reg, c1_reg;
    side_t              sd1_reg;
    // R2: second-order terms
    logic signed [33:0] txx_reg, txy_reg, txz_reg, tyy_reg, tyz_reg, tzz_reg;
    logic signed [33:0] sx2_reg, sy2_reg, sz2_reg, c2_reg;
    side_t              sd2_reg;
    // R3: matrix
    logic signed [33:0] m_reg [3][3];
    side_t              sd3_reg;
    // R4: scaled products
    logic signed [51:0] e_reg [3][3];
    logic signed [31:0] pv [3];

    assign pv[0] = $signed(sd3_reg.px);
    assign pv[1] = $signed(sd3_reg.py);
    assign pv[2] = $signed(sd3_reg.pz);

    logic signed [65:0] prod [3][3];
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                prod[i][j] = m_reg[i][j] * pv[j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tx1_reg <= mul30(omc_in, $signed(side_in.ux));
            ty1_reg <= mul30(omc_in, $signed(side_in.uy));
            tz1_reg <= mul30(omc_in, $signed(side_in.uz));
            sx1_reg <= mul30(sin_in, $signed(side_in.ux));
            sy1_reg <= mul30(sin_in, $signed(side_in.uy));
            sz1_reg <= mul30(sin_in, $signed(side_in.uz));
            c1_reg  <= cos_in;
            sd1_reg <= side_in;

            txx_reg <= mul30(tx1_reg, $signed(sd1_reg.ux));
            txy_reg <= mul30(tx1_reg, $signed(sd1_reg.uy));
            txz_reg <= mul30(tx1_reg, $signed(sd1_reg.uz));
            tyy_reg <= mul30(ty1_reg, $signed(sd1_reg.uy));
            tyz_reg <= mul30(ty1_reg, $signed(sd1_reg.uz));
            tzz_reg <= mul30(tz1_reg, $signed(sd1_reg.uz));
            sx2_reg <= sx1_reg;
            sy2_reg <= sy1_reg;
            sz2_reg <= sz1_reg;
            c2_reg  <= c1_reg;
            sd2_reg <= sd1_reg;

            m_reg[0][0] <= c2_reg + txx_reg;
            m_reg[0][1] <= txy_reg - sz2_reg;
            m_reg[0][2] <= txz_reg + sy2_reg;
            m_reg[1][0] <= txy_reg + sz2_reg;
            m_reg[1][1] <= c2_reg + tyy_reg;
            m_reg[1][2] <= tyz_reg - sx2_reg;
            m_reg[2][0] <= txz_reg - sy2_reg;
            m_reg[2][1] <= tyz_reg + sx2_reg;
            m_reg[2][2] <= c2_reg + tzz_reg;
            sd3_reg     <= sd2_reg;

            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    e_reg[i][j] <= prod[i][j][65:14];
                end
            end
        end
    end

    // R5: sum, round to Q16.16, saturate
    logic signed [53:0] sum [3];
    logic signed [53:0] rnd [3];
    logic signed [31:0] sat [3];
    logic [2:0]         ovf;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sum[i] = 54'(e_reg[i][0]) + 54'(e_reg[i][1]) + 54'(e_reg[i][2])
                     + 54'sd32768;
            rnd[i] = sum[i] >>> 16;
            if (rnd[i] > 54'sd2147483647)
            begin
                sat[i] = 32'sh7FFFFFFF;
                ovf[i] = 1'b1;
            end
            else if (rnd[i] < -54'sd2147483648)
            begin
                sat[i] = 32'sh80000000;
                ovf[i] = 1'b1;
            end
            else
            begin
                sat[i] = rnd[i][31:0];
                ovf[i] = 1'b0;
            end
        end
    end

    logic signed [31:0] ox_reg, oy_reg, oz_reg;
    logic               of_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ox_reg <= sat[0];
            oy_reg <= sat[1];
            oz_reg <= sat[2];
            of_reg <= |ovf;
        end
    end

    assign valid_out = v_reg[4];
    assign rot_x     = ox_reg;
    assign rot_y     = oy_reg;
    assign rot_z     = oz_reg;
    assign overflow  = of_reg;

endmodule

`default_nettype wire

FILE: src/aapr_checker.sv
// Port-level checker for the axis-angle point rotator, bound to the top level.
`default_nettype none

module aapr_checker (
    input wire               clk,
    input wire               rst_n,
    input wire               item_valid,
    input wire               item_stall,
    input wire signed [31:0] point_x,
    input wire signed [31:0] point_y,
    input wire signed [31:0] point_z,
    input wire signed [31:0] axis_x,
    input wire signed [31:0] axis_y,
    input wire signed [31:0] axis_z,
    input wire signed [25:0] angle_deg,
    input wire               rot_valid,
    input wire               rot_stall,
    input wire signed [31:0] rot_x,
    input wire signed [31:0] rot_y,
    input wire signed [31:0] rot_z,
    input wire               overflow
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rot_valid && rot_stall |=> rot_valid)
        else $error("output word dropped under stall");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rot_valid && rot_stall |=> $stable(rot_x) && $stable(rot_y) && $stable(rot_z)
                                   && $stable(overflow))
        else $error("output word changed under stall");

    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> rot_valid && rot_stall)
        else $error("input stalled without output back-pressure");

    a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
        rot_valid && overflow |->
            rot_x == 32'sh7FFFFFFF || rot_x == 32'sh80000000 ||
            rot_y == 32'sh7FFFFFFF || rot_y == 32'sh80000000 ||
            rot_z == 32'sh7FFFFFFF || rot_z == 32'sh80000000)
        else $error("overflow without a saturated coordinate");

endmodule

bind axis_angle_point_rotate aapr_checker u_aapr_checker (.*);

`default_nettype wire
